FILE: rtl/core/vrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrd_pkg
// Types and constants shared by the VP9 RTP depacketizer modules.
// ----------------------------------------------------------------------------
package vrd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Descriptor bit masks.
	localparam logic [7:0] MASK_I   = 8'h80;
	localparam logic [7:0] MASK_M   = 8'h80;
	localparam logic [7:0] MASK_L   = 8'h20;
	localparam logic [7:0] MASK_F   = 8'h10;
	localparam logic [7:0] MASK_PF  = 8'h50;
	localparam logic [7:0] MASK_V   = 8'h02;
	localparam logic [7:0] MASK_G   = 8'h08;
	localparam logic [7:0] MASK_N   = 8'h01;
	localparam logic [7:0] MASK_Y   = 8'h10;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_FIRST   = 4'd0,
		PH_PID     = 4'd1,
		PH_PID2    = 4'd2,
		PH_LAYER   = 4'd3,
		PH_TL0     = 4'd4,
		PH_PDIFF   = 4'd5,
		PH_SS_HDR  = 4'd6,
		PH_SS_RES  = 4'd7,
		PH_SS_NG   = 4'd8,
		PH_SS_GRP  = 4'd9,
		PH_SS_GREF = 4'd10,
		PH_DATA    = 4'd11,
		PH_DROP    = 4'd12
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        packet_start;
		logic        packet_end;
		logic [31:0] rtp_timestamp;
		logic        marker;
	} item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] payload_byte;
		logic       last_of_run;
	} result_t;

	// All results caused by one byte: up to two kinds and the data byte.
	typedef struct packed {
		logic [1:0] count;
		kind_t      kind0;
		kind_t      kind1;
		logic [7:0] data;
	} qent_t;

endpackage
`default_nettype wire

FILE: rtl/core/vrd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrd_front
// Descriptor parser: takes one payload byte per cycle while accept is high and
// turns it into a queue entry holding the results that byte causes.
// ----------------------------------------------------------------------------
module vrd_front
	import vrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t item,
	input  wire logic  accept,
	output qent_t      entry,
	output logic       entry_valid
);

	phase_t      phase_q,    phase_nx, cur;
	logic [7:0]  flags_q,    flags_nx;
	logic [5:0]  skip_q,     skip_nx;
	logic [7:0]  groups_q,   groups_nx;
	logic [1:0]  rdc_q,      rdc_nx;
	logic [31:0] ts_q,       ts_nx;
	logic        hasdata_q,  hasdata_nx;
	logic [1:0]  n;

	function automatic phase_t after_pdiff(input logic [7:0] f);
		return ((f & MASK_V) != 8'h00) ? PH_SS_HDR : PH_DATA;
	endfunction

	function automatic phase_t after_layer(input logic [7:0] f);
		return ((f & MASK_PF) == MASK_PF) ? PH_PDIFF : after_pdiff(f);
	endfunction

	function automatic phase_t after_pid(input logic [7:0] f);
		return ((f & MASK_L) != 8'h00) ? PH_LAYER : after_layer(f);
	endfunction

	function automatic phase_t after_ss_res(input logic [7:0] f);
		return ((f & MASK_G) != 8'h00) ? PH_SS_NG : PH_DATA;
	endfunction

	function automatic phase_t after_group(input logic [7:0] g);
		return (g != 8'h00) ? PH_SS_GRP : PH_DATA;
	endfunction

	always_comb begin
		phase_nx   = phase_q;
		flags_nx   = flags_q;
		skip_nx    = skip_q;
		groups_nx  = groups_q;
		rdc_nx     = rdc_q;
		ts_nx      = ts_q;
		hasdata_nx = hasdata_q;
		cur        = phase_q;
		n          = 2'd0;
		entry      = '0;
		entry.kind0 = KIND_DATA;
		entry.kind1 = KIND_DATA;

		if (item.packet_start) begin
			cur = PH_FIRST;
			if (item.rtp_timestamp != ts_q) begin
				if (hasdata_q) begin
					entry.kind0 = KIND_END;
					n = 2'd1;
				end
				hasdata_nx = 1'b0;
				ts_nx      = item.rtp_timestamp;
			end
		end
		phase_nx = cur;

		case (cur)
			PH_FIRST: begin
				flags_nx = item.data_byte;
				phase_nx = ((item.data_byte & MASK_I) != 8'h00) ? PH_PID
					: after_pid(item.data_byte);
			end
			PH_PID: begin
				phase_nx = ((item.data_byte & MASK_M) != 8'h00) ? PH_PID2
					: after_pid(flags_q);
			end
			PH_PID2:  phase_nx = after_pid(flags_q);
			PH_LAYER: begin
				phase_nx = ((flags_q & MASK_F) != 8'h00) ? after_layer(flags_q) : PH_TL0;
			end
			PH_TL0:   phase_nx = after_layer(flags_q);
			PH_PDIFF: begin
				if ((item.data_byte & MASK_N) == 8'h00) begin
					phase_nx = after_pdiff(flags_q);
				end else if (rdc_q >= 2'd2) begin
					if (n == 2'd0) entry.kind0 = KIND_ERR;
					else           entry.kind1 = KIND_ERR;
					n = n + 2'd1;
					phase_nx = PH_DROP;
				end else begin
					rdc_nx = rdc_q + 2'd1;
				end
			end
			PH_SS_HDR: begin
				flags_nx = item.data_byte;
				if ((item.data_byte & MASK_Y) != 8'h00) begin
					skip_nx  = {({1'b0, item.data_byte[7:5]} + 4'd1), 2'b00};
					phase_nx = PH_SS_RES;
				end else begin
					phase_nx = after_ss_res(item.data_byte);
				end
			end
			PH_SS_RES: begin
				skip_nx = (skip_q != 6'd0) ? skip_q - 6'd1 : skip_q;
				if (skip_nx == 6'd0) phase_nx = after_ss_res(flags_q);
			end
			PH_SS_NG: begin
				groups_nx = item.data_byte;
				phase_nx  = after_group(item.data_byte);
			end
			PH_SS_GRP: begin
				groups_nx = (groups_q != 8'h00) ? groups_q - 8'h01 : groups_q;
				if (item.data_byte[3:2] != 2'd0) begin
					skip_nx  = {4'd0, item.data_byte[3:2]};
					phase_nx = PH_SS_GREF;
				end else begin
					phase_nx = after_group(groups_nx);
				end
			end
			PH_SS_GREF: begin
				skip_nx = (skip_q != 6'd0) ? skip_q - 6'd1 : skip_q;
				if (skip_nx == 6'd0) phase_nx = after_group(groups_q);
			end
			PH_DATA: begin
				if (n == 2'd0) entry.kind0 = KIND_DATA;
				else           entry.kind1 = KIND_DATA;
				entry.data = item.data_byte;
				n = n + 2'd1;
				hasdata_nx = 1'b1;
			end
			PH_DROP: ;
			default: phase_nx = PH_DROP;
		endcase

		// The reference difference count restarts on entry to the list.
		if (phase_nx == PH_PDIFF && cur != PH_PDIFF) rdc_nx = 2'd0;

		if (item.packet_end) begin
			if (phase_nx == PH_DATA) begin
				if (item.marker && hasdata_nx) begin
					if (n == 2'd0) entry.kind0 = KIND_END;
					else           entry.kind1 = KIND_END;
					n = n + 2'd1;
					hasdata_nx = 1'b0;
				end
			end else if (phase_nx != PH_DROP) begin
				if (n == 2'd0) entry.kind0 = KIND_ERR;
				else           entry.kind1 = KIND_ERR;
				n = n + 2'd1;
			end
			phase_nx = PH_FIRST;
		end

		entry.count = n;
		entry_valid = accept && (n != 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			flags_q   <= '0;
			skip_q    <= '0;
			groups_q  <= '0;
			rdc_q     <= '0;
			ts_q      <= '0;
			hasdata_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_nx;
			flags_q   <= flags_nx;
			skip_q    <= skip_nx;
			groups_q  <= groups_nx;
			rdc_q     <= rdc_nx;
			ts_q      <= ts_nx;
			hasdata_q <= hasdata_nx;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/vrd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrd_queue
// Small FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module vrd_queue
	import vrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t push_entry,
	input  wire logic  pop,
	output qent_t      head,
	output logic       empty,
	output logic       full
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);
	localparam logic [CntW-1:0] CntOne  = CntW'(1);

	qent_t           mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FullCnt);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
			if (push && !pop)      count_q <= count_q + CntOne;
			else if (pop && !push) count_q <= count_q - CntOne;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/vrd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrd_back
// Output stage: unpacks each queue entry into one or two results and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
module vrd_back
	import vrd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire qent_t head,
	input  wire logic  empty,
	output logic       pop,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	logic    out_valid_q;
	logic    second_q;
	result_t out_q;
	logic    load;
	kind_t   kind_sel;
	result_t next_out;

	assign load = !out_valid_q || !result_stall;

	always_comb begin
		kind_sel              = second_q ? head.kind1 : head.kind0;
		next_out.result_kind  = kind_sel;
		next_out.payload_byte = (kind_sel == KIND_DATA) ? head.data : 8'h00;
		next_out.last_of_run  = second_q || (head.count == 2'd1);
		pop                   = load && !empty && next_out.last_of_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) second_q <= !next_out.last_of_run;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) out_q <= next_out;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/vp9_rtp_depacketizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vp9_rtp_depacketizer
// Strips the VP9 RTP payload descriptor and passes frame data bytes on,
// with frame-end and invalid-packet marks.
// ----------------------------------------------------------------------------
// The block takes one payload byte per clock cycle while item_stall is low.
// The parser decides in the same cycle what each byte causes and writes it
// as one entry into a queue of QUEUE_DEPTH entries; the output stage hands
// out one result per cycle while result_stall is low. A byte that causes no
// result writes no entry; one that causes two (a frame end next to a data
// byte or an error) holds the output stage for both, which the queue absorbs
// between such bytes. Results pass the queue, then the output register.
module vp9_rtp_depacketizer
	import vrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	qent_t entry, head;
	logic  entry_valid, accept, full, empty, pop;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	vrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.accept      (accept),
		.entry       (entry),
		.entry_valid (entry_valid)
	);

	vrd_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (entry_valid),
		.push_entry (entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	vrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire
